// ===== sv/swsfr_pkg.sv =====
// swsfr_pkg: shared constants, codes and derived widths of the sliding window sender.
// No dependencies; the sender RTL refers to it by scoped names.
package swsfr_pkg;

   // ring geometry and stored payload width
   localparam int RING_DEPTH   = 8;
   localparam int PAYLOAD_BITS = 32;
   localparam int RING_AW      = $clog2(RING_DEPTH);
   // a remainder before its final correction stays below 2 * RING_DEPTH
   localparam int SLOT_RW      = $clog2(2 * RING_DEPTH);

   // seq mod RING_DEPTH by reciprocal: q = (seq * RECIP) >> RECIP_SHIFT is q_true or q_true - 1
   localparam int RECIP_SHIFT  = 32 + $clog2(RING_DEPTH) - 1;
   localparam logic [31:0] RECIP =
      32'(((64'd1 << RECIP_SHIFT) - 64'd1) / 64'(RING_DEPTH));

   // field widths
   localparam int SEQ_W  = 32;
   localparam int FUNC_W = 2;
   localparam int KIND_W = 3;
   localparam int WIN_W  = 4;
   localparam int THR_W  = 3;
   localparam int CSR_IDX_W = 2;

   // item kinds
   localparam logic [FUNC_W-1:0] FN_SEND    = 2'd0;
   localparam logic [FUNC_W-1:0] FN_ACK     = 2'd1;
   localparam logic [FUNC_W-1:0] FN_TIMEOUT = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] K_REFUSED = 3'd0;
   localparam logic [KIND_W-1:0] K_SENT    = 3'd1;
   localparam logic [KIND_W-1:0] K_SLID    = 3'd2;
   localparam logic [KIND_W-1:0] K_FAST    = 3'd3;
   localparam logic [KIND_W-1:0] K_TIMEOUT = 3'd4;
   localparam logic [KIND_W-1:0] K_IGNORED = 3'd5;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUP_THR = 2'd1;

   // reset values
   localparam logic [WIN_W-1:0] WINDOW_RST  = 4'd4;
   localparam logic [THR_W-1:0] DUP_THR_RST = 3'd4;
   localparam logic [SEQ_W-1:0] SEQ_RST     = 32'd1;

endpackage

// ===== sv/swsfr_ram.sv =====
// swsfr_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module swsfr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sliding_window_sender_fast_retx.sv =====
// Go-back-N sender with fast retransmit: one result beat per request beat.
// Send, ack and refused beats give their result in the cycle after acceptance; fast retransmit
// and timeout beats pass reciprocal multiply, slot fix-up + ring read, read data to output.
// Throughput: 1 beat/cycle without a ring read when rsp_stall is low; a beat with one stalls new
// requests until its result is loaded (single ring read port, two-stage slot computation).
// Reset (sync, active high): base = next = 1, dup count 0, window 4, threshold 4; ring not cleared.
module sliding_window_sender_fast_retx (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [swsfr_pkg::FUNC_W-1:0]         req_func,
   input  logic [31:0]                          req_payload,
   input  logic [31:0]                          req_ack_number,
   input  logic                                 req_ack_checksum_ok,
   input  logic [31:0]                          req_timeout_seq,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [swsfr_pkg::KIND_W-1:0]         rsp_kind,
   output logic [31:0]                          rsp_tx_seq,
   output logic [31:0]                          rsp_tx_payload,
   output logic [31:0]                          rsp_stop_first,
   output logic [31:0]                          rsp_stop_end,
   // configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [swsfr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [swsfr_pkg::WIN_W-1:0]          csr_data
);

   localparam int SEQ_W   = swsfr_pkg::SEQ_W;
   localparam int AW      = swsfr_pkg::RING_AW;
   localparam int RW      = swsfr_pkg::SLOT_RW;
   localparam int DEPTH   = swsfr_pkg::RING_DEPTH;
   localparam int PB      = swsfr_pkg::PAYLOAD_BITS;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;   // takes request beats
   localparam logic [1:0] ST_MOD  = 2'd1;   // fix up slot, issue ring read
   localparam logic [1:0] ST_RD   = 2'd2;   // ring data ready, wait for output register

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   logic [1:0]                    state_ff,     state_in;
   logic [swsfr_pkg::WIN_W-1:0]   window_ff,    window_in;
   logic [swsfr_pkg::THR_W-1:0]   dup_thr_ff,   dup_thr_in;
   logic [SEQ_W-1:0]              base_seq_ff,  base_seq_in;
   logic [SEQ_W-1:0]              next_seq_ff,  next_seq_in;
   logic [AW-1:0]                 next_slot_ff, next_slot_in;
   logic [swsfr_pkg::THR_W-1:0]   dup_cnt_ff,   dup_cnt_in;

   // pending ring read: kind, sequence, reciprocal quotient estimate
   logic [swsfr_pkg::KIND_W-1:0]  pend_kind_ff, pend_kind_in;
   logic [SEQ_W-1:0]              pend_seq_ff,  pend_seq_in;
   logic [SEQ_W-1:0]              quot_ff,      quot_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [swsfr_pkg::KIND_W-1:0]  rsp_kind_ff,  rsp_kind_in;
   logic [31:0]                   rsp_seq_ff,   rsp_seq_in;
   logic [31:0]                   rsp_pay_ff,   rsp_pay_in;
   logic [31:0]                   rsp_first_ff, rsp_first_in;
   logic [31:0]                   rsp_end_ff,   rsp_end_in;

   // ------------------------------------------------------------------
   // combinational decode
   // ------------------------------------------------------------------
   logic                 out_free;
   logic                 accept;
   logic                 refuse;
   logic [SEQ_W:0]       win_ext;
   logic [SEQ_W:0]       win_limit;
   logic [swsfr_pkg::THR_W-1:0] dup_inc;
   logic [SEQ_W-1:0]     rd_seq;
   logic [2*SEQ_W-1:0]   prod;
   logic [RW-1:0]        qd_low;
   logic [RW-1:0]        rem;
   logic [AW-1:0]        rd_slot;
   logic                 ring_wr;
   logic                 ring_rd;
   logic [PB-1:0]        ring_rdata;

   // output register frees up when empty or drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // window saturates at the ring depth; limit formed at 33 bits so it never wraps
   assign win_ext   = (33'(window_ff) > 33'(DEPTH)) ? 33'(DEPTH) : 33'(window_ff);
   assign win_limit = {1'b0, base_seq_ff} + win_ext;
   assign refuse    = {1'b0, next_seq_ff} >= win_limit;
   assign dup_inc   = dup_cnt_ff + 3'd1;

   // sequence whose slot is read: base for fast retransmit, else the expired timer
   assign rd_seq = (req_func == swsfr_pkg::FN_ACK) ? base_seq_ff : req_timeout_seq;
   assign prod   = {32'd0, rd_seq} * {32'd0, swsfr_pkg::RECIP};

   // slot = seq - q*DEPTH, needs only the low bits; one correction step
   assign qd_low  = RW'(quot_ff[RW-1:0]) * RW'(DEPTH);
   assign rem     = pend_seq_ff[RW-1:0] - qd_low;
   assign rd_slot = (rem >= RW'(DEPTH)) ? AW'(rem - RW'(DEPTH)) : AW'(rem);

   assign ring_wr = accept && (req_func == swsfr_pkg::FN_SEND) && !refuse;
   assign ring_rd = (state_ff == ST_MOD);

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      dup_thr_in   = dup_thr_ff;
      base_seq_in  = base_seq_ff;
      next_seq_in  = next_seq_ff;
      next_slot_in = next_slot_ff;
      dup_cnt_in   = dup_cnt_ff;
      pend_kind_in = pend_kind_ff;
      pend_seq_in  = pend_seq_ff;
      quot_in      = quot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_seq_in   = rsp_seq_ff;
      rsp_pay_in   = rsp_pay_ff;
      rsp_first_in = rsp_first_ff;
      rsp_end_in   = rsp_end_ff;

      // config writes must arrive only while idle; the block itself does not enforce it
      if (csr_valid && csr_ready) begin
         case (csr_index)
            swsfr_pkg::CSR_WINDOW:  window_in  = csr_data;
            swsfr_pkg::CSR_DUP_THR: dup_thr_in = csr_data[swsfr_pkg::THR_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // default: immediate result with all payload fields zero
               rsp_valid_in = 1'b1;
               rsp_kind_in  = swsfr_pkg::K_IGNORED;
               rsp_seq_in   = '0;
               rsp_pay_in   = '0;
               rsp_first_in = '0;
               rsp_end_in   = '0;
               quot_in      = 32'(prod >> swsfr_pkg::RECIP_SHIFT);
               pend_seq_in  = rd_seq;
               case (req_func)
                  swsfr_pkg::FN_SEND: begin
                     if (refuse) begin
                        rsp_kind_in = swsfr_pkg::K_REFUSED;
                     end else begin
                        rsp_kind_in = swsfr_pkg::K_SENT;
                        rsp_seq_in  = next_seq_ff;
                        rsp_pay_in  = 32'(PB'(req_payload));
                        next_seq_in = next_seq_ff + 32'd1;
                        // slot follows the sequence; a 32-bit wrap lands on slot 0
                        if ((next_seq_ff == '1) || (next_slot_ff == AW'(DEPTH - 1))) begin
                           next_slot_in = '0;
                        end else begin
                           next_slot_in = next_slot_ff + AW'(1);
                        end
                     end
                  end
                  swsfr_pkg::FN_ACK: begin
                     if (!req_ack_checksum_ok || (req_ack_number < base_seq_ff)) begin
                        rsp_kind_in = swsfr_pkg::K_IGNORED;
                     end else if (req_ack_number > base_seq_ff) begin
                        rsp_kind_in  = swsfr_pkg::K_SLID;
                        rsp_first_in = base_seq_ff;
                        rsp_end_in   = req_ack_number;
                        dup_cnt_in   = '0;
                        base_seq_in  = req_ack_number;
                     end else if (next_seq_ff <= base_seq_ff) begin
                        // nothing outstanding at base
                        rsp_kind_in = swsfr_pkg::K_IGNORED;
                     end else if (dup_inc == dup_thr_ff) begin
                        // fast retransmit: result comes after the ring read
                        dup_cnt_in   = '0;
                        rsp_valid_in = 1'b0;
                        pend_kind_in = swsfr_pkg::K_FAST;
                        state_in     = ST_MOD;
                     end else begin
                        dup_cnt_in  = dup_inc;
                        rsp_kind_in = swsfr_pkg::K_IGNORED;
                     end
                  end
                  swsfr_pkg::FN_TIMEOUT: begin
                     rsp_valid_in = 1'b0;
                     pend_kind_in = swsfr_pkg::K_TIMEOUT;
                     state_in     = ST_MOD;
                  end
                  default: begin
                     rsp_kind_in = swsfr_pkg::K_IGNORED;
                  end
               endcase
            end
         end
         ST_MOD: begin
            state_in = ST_RD;
         end
         ST_RD: begin
            // ring data holds until the output register takes it
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_kind_ff;
               rsp_seq_in   = pend_seq_ff;
               rsp_pay_in   = 32'(ring_rdata);
               rsp_first_in = '0;
               rsp_end_in   = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= swsfr_pkg::WINDOW_RST;
         dup_thr_ff   <= swsfr_pkg::DUP_THR_RST;
         base_seq_ff  <= swsfr_pkg::SEQ_RST;
         next_seq_ff  <= swsfr_pkg::SEQ_RST;
         next_slot_ff <= AW'(1);
         dup_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         dup_thr_ff   <= dup_thr_in;
         base_seq_ff  <= base_seq_in;
         next_seq_ff  <= next_seq_in;
         next_slot_ff <= next_slot_in;
         dup_cnt_ff   <= dup_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload-side registers, no reset needed
   always_ff @(posedge clock) begin
      pend_kind_ff <= pend_kind_in;
      pend_seq_ff  <= pend_seq_in;
      quot_ff      <= quot_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_seq_ff   <= rsp_seq_in;
      rsp_pay_ff   <= rsp_pay_in;
      rsp_first_ff <= rsp_first_in;
      rsp_end_ff   <= rsp_end_in;
   end

   // ------------------------------------------------------------------
   // packet ring
   // ------------------------------------------------------------------
   swsfr_ram #(
      .WIDTH (PB),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (next_slot_ff),
      .wr_data (PB'(req_payload)),
      .rd_en   (ring_rd),
      .rd_addr (rd_slot),
      .rd_data (ring_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_tx_seq     = rsp_seq_ff;
   assign rsp_tx_payload = rsp_pay_ff;
   assign rsp_stop_first = rsp_first_ff;
   assign rsp_stop_end   = rsp_end_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // corrected slot always lands inside the ring
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD) |-> ({1'b0, rem} < (RW + 1)'(2 * DEPTH)) &&
                               ({1'b0, rd_slot} < (AW + 1)'(DEPTH)))
      else $error("ring slot out of range");

   // slot fix-up always hands over to the read stage
   a_mod_to_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD) |=> (state_ff == ST_RD))
      else $error("slot stage did not advance");

   // read data is delivered as soon as the output register is free
   a_rd_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD) && out_free |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("read result not loaded");

   // a response appears only from an accepted beat or a completed ring read
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept) || $past(state_ff == ST_RD))
      else $error("response without a source");

endmodule
